### rtl/core/tmce_pkg.sv
// shared types, sizes and codes for the text mode console engine
// no dependencies; used by every module in rtl/core
package tmce_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // field widths of the items
  localparam int KIND_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IN_COL_W  = 7;
  localparam int IN_ROW_W  = 5;
  localparam int CELL_W    = 16;
  localparam int POS_W     = 11;

  // derived storage and cursor widths
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int CUR_COL_W = $clog2(COLUMNS);
  localparam int CUR_ROW_W = $clog2(ROWS);

  // address unit operand widths
  localparam int AU_ROW_W  = (IN_ROW_W > CUR_ROW_W) ? IN_ROW_W : CUR_ROW_W;
  localparam int AU_OFF_W  = (IN_COL_W > CELL_AW) ? IN_COL_W : CELL_AW;
  localparam int SUM_W     = $clog2(((2 ** AU_ROW_W) - 1) * COLUMNS + (2 ** AU_OFF_W));

  // sweep limits
  localparam int SCROLL_LAST = CELLS - COLUMNS - 1;
  localparam int LAST_ROW_AT = CELLS - COLUMNS;

  // character and attribute constants
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUT    = 3'd0,
    KIND_CLEAR  = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CURSOR = 3'd4
  } kind_t;

  // address unit request and response
  typedef struct packed {
    logic [AU_ROW_W-1:0] row;
    logic [AU_OFF_W-1:0] offset;
  } au_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             in_range;
  } au_rsp_t;

  // ram write port
  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
    logic [CELL_W-1:0]  data;
  } ram_wr_t;

endpackage

### rtl/core/tmce_cell_ram.sv
// screen cell store: one write port, one read port with registered data
// depends on tmce_pkg for sizes and the write port struct
module tmce_cell_ram (
  input  logic                              clk,
  input  tmce_pkg::ram_wr_t                 wr,
  input  logic [tmce_pkg::CELL_AW-1:0]      raddr,
  output logic [tmce_pkg::CELL_W-1:0]       rdata
);

  logic [tmce_pkg::CELL_W-1:0] mem [tmce_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tmce_addr_unit.sv
// shared address unit: row * COLUMNS + offset and a bound check on the cell count
// depends on tmce_pkg for widths and the request/response structs
module tmce_addr_unit (
  input  tmce_pkg::au_req_t req,
  output tmce_pkg::au_rsp_t rsp
);

  logic [tmce_pkg::SUM_W-1:0] row_base;

  always_comb begin
    row_base     = tmce_pkg::SUM_W'(req.row) * tmce_pkg::SUM_W'(tmce_pkg::COLUMNS);
    rsp.sum      = row_base + tmce_pkg::SUM_W'(req.offset);
    rsp.in_range = rsp.sum < tmce_pkg::SUM_W'(tmce_pkg::CELLS);
  end

endmodule

### rtl/core/text_mode_console_engine.sv
// text mode console engine top level: sequencer, cursor state and result register
// depends on tmce_pkg, tmce_cell_ram and tmce_addr_unit
// an item is taken only in idle and runs the exec state (a cell read also the read state),
// then the done state loads the result register, waiting while it is full; no new item is
// taken before that; a clear blanks every cell, a scroll copies rows up then blanks the last row
// reset: synchronous; then a pass blanks the screen, no item is taken meanwhile
module text_mode_console_engine (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // char_code[7:0], attribute[15:8], column[22:16], row[27:23]
  input  logic [2:0]  s_tuser,  // kind[2:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cell_value[15:0], cursor_position[26:16]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;

  // latched item fields
  logic [tmce_pkg::KIND_W-1:0]   kind_r;
  logic [tmce_pkg::CHAR_W-1:0]   ch_r;
  logic [tmce_pkg::ATTR_W-1:0]   attr_r;
  logic [tmce_pkg::IN_COL_W-1:0] col_r;
  logic [tmce_pkg::IN_ROW_W-1:0] row_r;

  // console state; the current attribute always comes from the item that uses it
  logic [tmce_pkg::CUR_COL_W-1:0] cursor_col;
  logic [tmce_pkg::CUR_ROW_W-1:0] cursor_row;

  // sweep control for fill and scroll
  logic [tmce_pkg::CELL_AW-1:0] idx;
  logic [tmce_pkg::CELL_W-1:0]  fill_cell;
  logic                         report;
  logic                         copy_valid;
  logic [tmce_pkg::CELL_AW-1:0] wr_addr;
  logic                         rd_ok;

  // result
  logic [tmce_pkg::CELL_W-1:0] cell_val;
  logic                        out_valid;
  logic [tmce_pkg::CELL_W-1:0] out_cell;
  logic [tmce_pkg::POS_W-1:0]  out_pos;

  tmce_pkg::au_req_t au_req;
  tmce_pkg::au_rsp_t au_rsp;
  tmce_pkg::ram_wr_t ram_wr;
  logic [tmce_pkg::CELL_W-1:0] rd_data;

  logic at_last_col;
  logic at_last_row;
  logic col_zero;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(32 - tmce_pkg::POS_W - tmce_pkg::CELL_W){1'b0}}, out_pos, out_cell};

  assign at_last_col = (cursor_col == tmce_pkg::CUR_COL_W'(tmce_pkg::COLUMNS - 1));
  assign at_last_row = (cursor_row == tmce_pkg::CUR_ROW_W'(tmce_pkg::ROWS - 1));
  assign col_zero    = (cursor_col == '0);

  tmce_addr_unit u_addr (
    .req (au_req),
    .rsp (au_rsp)
  );

  tmce_cell_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (tmce_pkg::CELL_AW'(au_rsp.sum)),
    .rdata (rd_data)
  );

  // operand select for the shared address unit
  always_comb begin
    au_req.row    = tmce_pkg::AU_ROW_W'(cursor_row);
    au_req.offset = tmce_pkg::AU_OFF_W'(cursor_col);
    unique case (state)
      S_EXEC: begin
        if (kind_r == tmce_pkg::KIND_WRITE || kind_r == tmce_pkg::KIND_READ) begin
          au_req.row    = tmce_pkg::AU_ROW_W'(row_r);
          au_req.offset = tmce_pkg::AU_OFF_W'(col_r);
        end else if (ch_r == tmce_pkg::CH_BACKSPACE) begin
          // the cell left of the cursor
          au_req.offset = tmce_pkg::AU_OFF_W'(cursor_col - 1'b1);
        end
      end
      S_SCROLL: begin
        // source cell one row below the destination
        au_req.row    = tmce_pkg::AU_ROW_W'(1);
        au_req.offset = tmce_pkg::AU_OFF_W'(idx);
      end
      default: begin
      end
    endcase
  end

  // single write port: scroll copy first, then fills, then item writes
  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.addr = idx;
    ram_wr.data = fill_cell;
    if (copy_valid) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = wr_addr;
      ram_wr.data = rd_data;
    end else if (state == S_FILL) begin
      ram_wr.en = 1'b1;
    end else if (state == S_EXEC) begin
      ram_wr.addr = tmce_pkg::CELL_AW'(au_rsp.sum);
      if (kind_r == tmce_pkg::KIND_WRITE) begin
        ram_wr.en   = au_rsp.in_range;
        ram_wr.data = {attr_r, ch_r};
      end else if (kind_r == tmce_pkg::KIND_PUT) begin
        if (ch_r == tmce_pkg::CH_BACKSPACE) begin
          ram_wr.en   = !col_zero && au_rsp.in_range;
          ram_wr.data = {attr_r, tmce_pkg::CH_BLANK};
        end else if (ch_r != tmce_pkg::CH_NEWLINE && ch_r != tmce_pkg::CH_RETURN) begin
          ram_wr.en   = au_rsp.in_range;
          ram_wr.data = {attr_r, ch_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      idx        <= '0;
      fill_cell  <= {tmce_pkg::RESET_ATTR, tmce_pkg::CH_BLANK};
      report     <= 1'b0;
      copy_valid <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a copy read in the scroll state is written back in the next cycle
      copy_valid <= (state == S_SCROLL);
      // the done state reloads the result register itself
      if (out_valid && m_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r <= s_tuser;
            ch_r   <= s_tdata[7:0];
            attr_r <= s_tdata[15:8];
            col_r  <= s_tdata[22:16];
            row_r  <= s_tdata[27:23];
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          cell_val <= '0;
          unique case (kind_r)
            tmce_pkg::KIND_PUT: begin
              if (ch_r == tmce_pkg::CH_RETURN) begin
                cursor_col <= '0;
                state      <= S_DONE;
              end else if (ch_r == tmce_pkg::CH_BACKSPACE) begin
                if (!col_zero) begin
                  cursor_col <= cursor_col - 1'b1;
                end
                state <= S_DONE;
              end else if (ch_r != tmce_pkg::CH_NEWLINE && !at_last_col) begin
                cursor_col <= cursor_col + 1'b1;
                state      <= S_DONE;
              end else begin
                // newline or wrap past the line end
                cursor_col <= '0;
                if (at_last_row) begin
                  idx       <= '0;
                  fill_cell <= {attr_r, tmce_pkg::CH_BLANK};
                  state     <= S_SCROLL;
                end else begin
                  cursor_row <= cursor_row + 1'b1;
                  state      <= S_DONE;
                end
              end
            end
            tmce_pkg::KIND_CLEAR: begin
              cursor_col <= '0;
              cursor_row <= '0;
              idx        <= '0;
              fill_cell  <= {attr_r, tmce_pkg::CH_BLANK};
              report     <= 1'b1;
              state      <= S_FILL;
            end
            tmce_pkg::KIND_READ: begin
              rd_ok <= au_rsp.in_range;
              state <= S_READ;
            end
            tmce_pkg::KIND_CURSOR: begin
              cursor_col <= (32'(col_r) < tmce_pkg::COLUMNS) ?
                            tmce_pkg::CUR_COL_W'(col_r) :
                            tmce_pkg::CUR_COL_W'(tmce_pkg::COLUMNS - 1);
              cursor_row <= (32'(row_r) < tmce_pkg::ROWS) ?
                            tmce_pkg::CUR_ROW_W'(row_r) :
                            tmce_pkg::CUR_ROW_W'(tmce_pkg::ROWS - 1);
              state      <= S_DONE;
            end
            default: begin
              // cell write is done by the write port; unused kinds change nothing
              state <= S_DONE;
            end
          endcase
        end

        S_READ: begin
          cell_val <= rd_ok ? rd_data : '0;
          state    <= S_DONE;
        end

        S_SCROLL: begin
          // read one row down now, write the data back next cycle
          wr_addr <= idx;
          if (idx == tmce_pkg::CELL_AW'(tmce_pkg::SCROLL_LAST)) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_DRAIN: begin
          // last copy goes out this cycle; then blank the bottom row
          idx    <= tmce_pkg::CELL_AW'(tmce_pkg::LAST_ROW_AT);
          report <= 1'b1;
          state  <= S_FILL;
        end

        S_FILL: begin
          if (idx == tmce_pkg::CELL_AW'(tmce_pkg::CELLS - 1)) begin
            state <= report ? S_DONE : S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_cell  <= cell_val;
            out_pos   <= tmce_pkg::POS_W'(au_rsp.sum);
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
